[design/assert_macros.svh]
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define U8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define U8D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/u8d_pkg.sv]
// Shared types, constants and decode functions of the UTF-8 stream decoder.
`default_nettype none

package u8d_pkg;

  localparam int CpWidth   = 21;
  localparam int FifoDepth = 4;
  localparam int PtrWidth  = $clog2(FifoDepth);
  localparam int CntWidth  = $clog2(FifoDepth + 1);

  typedef logic [2:0] seq_len_t;

  localparam seq_len_t LEN1 = 3'd1;
  localparam seq_len_t LEN2 = 3'd2;
  localparam seq_len_t LEN3 = 3'd3;
  localparam seq_len_t LEN4 = 3'd4;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               last_of_run;
  } result_t;

  // Results of one accepted byte, count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

  function automatic seq_len_t seq_len(input logic [7:0] b);
    seq_len_t l;
    if (!b[7]) begin
      l = LEN1;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      l = LEN2;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      l = LEN3;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      l = LEN4;
    end else begin
      l = LEN1;
    end
    return l;
  endfunction

  function automatic logic [CpWidth-1:0] decode_seq(input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic [7:0] b2,
                                                    input logic [7:0] b3,
                                                    input seq_len_t   len);
    logic [CpWidth-1:0] cp;
    unique case (len)
      LEN2:    cp = {10'd0, b0[4:0], b1[5:0]};
      LEN3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      LEN4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

[design/u8d_decode.sv]
// Byte decoder: pending sequence registers and single-pass code point decode.
`default_nettype none
`include "assert_macros.svh"

module u8d_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_eos,
  output u8d_pkg::dec_out_t      dec
);
  import u8d_pkg::*;

  logic [1:0]          pend_cnt_r;
  logic [1:0]          pend_cnt_nxt;
  logic [7:0]          pend_r [3];

  logic [7:0]          sb0, sb1, sb2, sb3;
  logic [2:0]          held;
  seq_len_t            need;
  seq_len_t            l1, l2;
  logic                complete;
  logic                store;
  logic [CpWidth-1:0]  a_val, b_val;
  logic                a_vld, b_vld;

  // Assemble the sequence: held bytes first, then the incoming byte.
  always_comb begin
    sb0 = (pend_cnt_r == 2'd0) ? in_byte : pend_r[0];
    sb1 = (pend_cnt_r == 2'd1) ? in_byte : ((pend_cnt_r > 2'd1) ? pend_r[1] : 8'h00);
    sb2 = (pend_cnt_r == 2'd2) ? in_byte : ((pend_cnt_r == 2'd3) ? pend_r[2] : 8'h00);
    sb3 = (pend_cnt_r == 2'd3) ? in_byte : 8'h00;
    held     = {1'b0, pend_cnt_r} + 3'd1;
    need     = seq_len(sb0);
    l1       = seq_len(sb1);
    l2       = seq_len(sb2);
    complete = (held >= need);
    store    = in_fire && !complete && !in_eos;
  end

  // Candidate results: a finished sequence, or the rescan of an unfinished one.
  always_comb begin
    a_val = decode_seq(sb0, sb1, sb2, sb3, need);
    a_vld = 1'b0;
    b_val = {13'd0, sb2};
    b_vld = 1'b0;
    if (complete) begin
      a_vld = 1'b1;
    end else if (in_eos) begin
      // Drop the lead byte and rescan what follows it.
      priority if (pend_cnt_r == 2'd2) begin
        if (l1 == LEN1) begin
          a_val = {13'd0, sb1};
          a_vld = 1'b1;
          b_vld = (l2 == LEN1);
        end else if (l1 == LEN2) begin
          a_val = decode_seq(sb1, sb2, 8'h00, 8'h00, LEN2);
          a_vld = 1'b1;
        end else begin
          b_vld = (l2 == LEN1);
        end
      end else if (pend_cnt_r == 2'd1) begin
        a_val = {13'd0, sb1};
        a_vld = (l1 == LEN1);
      end else begin
        a_vld = 1'b0;
      end
    end
    // Zero values never leave the block.
    a_vld = a_vld && (a_val != '0);
    b_vld = b_vld && (b_val != '0);
  end

  // Pack the surviving candidates, flag the final one of this byte.
  always_comb begin
    dec.count          = in_fire ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
    dec.r0.code_point  = a_vld ? a_val : b_val;
    dec.r0.last_of_run = !(a_vld && b_vld);
    dec.r1.code_point  = b_val;
    dec.r1.last_of_run = 1'b1;
  end

  always_comb begin
    pend_cnt_nxt = pend_cnt_r;
    if (in_fire) begin
      pend_cnt_nxt = store ? (pend_cnt_r + 2'd1) : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
    end else begin
      pend_cnt_r <= pend_cnt_nxt;
    end
  end

  // Hold the byte of an open sequence; no reset on payload.
  always_ff @(posedge clk) begin
    if (store && (pend_cnt_r != 2'd3)) begin
      pend_r[pend_cnt_r] <= in_byte;
    end
  end

  `U8D_ASSERT(a_eos_clears, (in_fire && in_eos) |=> (pend_cnt_r == 2'd0), "pending bytes survive end of string")
  `U8D_ASSERT(a_two_only_at_eos, (dec.count == 2'd2) |-> (in_fire && in_eos && !complete), "two results outside end-of-string rescan")

endmodule

`default_nettype wire

[design/u8d_fifo.sv]
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
`default_nettype none
`include "assert_macros.svh"

module u8d_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire u8d_pkg::dec_out_t dec,
  output logic                   space_ok,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output u8d_pkg::result_t       out_res
);
  import u8d_pkg::*;

  result_t               mem [FifoDepth];
  logic [PtrWidth-1:0]   wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [PtrWidth-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntWidth-1:0]   cnt_r, cnt_nxt;
  logic                  pop;

  always_comb begin
    pop        = out_valid && out_ready;
    wr_ptr1    = wr_ptr_r + PtrWidth'(1);
    wr_ptr_nxt = wr_ptr_r + PtrWidth'(dec.count);
    rd_ptr_nxt = rd_ptr_r + PtrWidth'(pop);
    cnt_nxt    = cnt_r + CntWidth'(dec.count) - CntWidth'(pop);
  end

  // Two free slots guarantee room for the worst case of one byte.
  assign space_ok  = (cnt_r <= CntWidth'(FifoDepth - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec.count != 2'd0) begin
      mem[wr_ptr_r] <= dec.r0;
    end
    if (dec.count == 2'd2) begin
      mem[wr_ptr1] <= dec.r1;
    end
  end

  `U8D_ASSERT(a_push_has_room, (dec.count != 2'd0) |-> (cnt_r <= CntWidth'(FifoDepth - 2)), "result queue overflow")
  `U8D_ASSERT(a_pop_only_drains, (pop && dec.count == 2'd0) |=> (cnt_r == $past(cnt_r) - CntWidth'(1)), "queue count lost a pop")
  `U8D_ASSERT(a_count_bound, cnt_r <= CntWidth'(FifoDepth), "queue count beyond depth")

endmodule

`default_nettype wire

[design/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: byte input, code point output.
//
// Usage:
//   Input channel: one raw byte per transaction on in_tdata[7:0], with in_tlast
//   high on the final byte of a string.
//   Output channel: one code point per transaction on out_tdata[20:0], with
//   out_tlast high on the final result caused by a given input byte. Zero
//   values are never emitted, so many bytes produce no transaction at all.
//   A result is written into the result queue and is presented from there.
//   Throughput: one byte per cycle while in_tready is high. A string that ends
//   inside a sequence can yield two results from its final byte; the second
//   drains after the first. The decode is one combinational pass from the
//   pending-byte registers and the incoming byte into a four-entry result queue.
//   in_tready is driven from the queue fill alone: it stays high while two
//   slots are free, so a stalled receiver backs the input off after the queue
//   fills, and no result is ever lost or repeated.
//   Reset (rst_n low, synchronous) drops any pending partial sequence and
//   empties the result queue.
`default_nettype none

module utf8_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tlast,   // end_of_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [20:0] code_point, [23:21] zero
  output logic             out_tlast   // last_of_run
);
  import u8d_pkg::*;

  dec_out_t dec;
  result_t  out_res;
  logic     in_fire;
  logic     space_ok;

  // Take a byte whenever the queue can absorb its worst case.
  assign in_tready = space_ok;
  assign in_fire   = in_tvalid && in_tready;

  u8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_eos  (in_tlast),
    .dec     (dec)
  );

  u8d_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pad the code point to whole bytes.
  assign out_tdata = {3'b000, out_res.code_point};
  assign out_tlast = out_res.last_of_run;

endmodule

`default_nettype wire
